FILE: rtl/sacc_pkg.sv
package sacc_pkg;

  localparam int MAX_SETS_DEF  = 256;
  localparam int MAX_WAYS_DEF  = 8;
  localparam int ADDR_BITS_DEF = 32;
  localparam int TAG_W         = 30;
  localparam int STAMP_W       = 32;
  localparam int CNT_W         = 32;
  localparam int FPTR_W        = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USE_LRU    = 3'd0,
    CFG_WRITE_BACK = 3'd1,
    CFG_BLK_BITS   = 3'd2,
    CFG_SET_BITS   = 3'd3,
    CFG_WAYS_LOG2  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic clear;
    logic lookup;
    logic update;
  } sacc_cmd_t;

  typedef struct packed {
    logic       use_lru;
    logic       write_back;
    logic [3:0] blk_bits;
    logic [3:0] set_bits;
    logic [1:0] ways_log2;
  } sacc_cfg_t;

endpackage

FILE: rtl/set_assoc_cache_controller_top.sv
// Channel  | Signals                   | Word
// in_      | tvalid tready tdata[39:0] | address, command
// out_     | tvalid tready tdata[135:0]| hit, fill, writes, way, four totals
// cfg_     | we idx[2:0] data[3:0]     | register write, no handshake
// Each access is accepted with a tag/stamp/pointer read, then compared, then updated.
// out_tvalid rises as the update state ends; the next word is taken no sooner.
// Reset is synchronous; then a clearing pass over all MAX_SETS sets (256 by default)
// zeroes valid, dirty, stamps and pointers while in_tready stays low.
// in_tready holds low while an access runs or a result is stalled.
module set_assoc_cache_controller_top
  import sacc_pkg::*;
#(
  parameter int MAX_SETS  = MAX_SETS_DEF,
  parameter int MAX_WAYS  = MAX_WAYS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [39:0]           in_tdata,   // address[31:0], command[32]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // hit, line_fill, writes_added[2], way_used[3], hit/miss/read/write totals, pad
  output logic [135:0]          out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sacc_cfg_t cfg_r;
  sacc_cmd_t cmd;
  logic      out_busy, in_fire, clr_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{use_lru: 1'b0, write_back: 1'b0, blk_bits: 4'd5,
                 set_bits: 4'd4, ways_log2: 2'd0};
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_USE_LRU:    cfg_r.use_lru    <= cfg_data[0];
        CFG_WRITE_BACK: cfg_r.write_back <= cfg_data[0];
        CFG_BLK_BITS:   cfg_r.blk_bits   <= cfg_data;
        CFG_SET_BITS:   cfg_r.set_bits   <= cfg_data;
        CFG_WAYS_LOG2:  cfg_r.ways_log2  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign in_fire = in_tvalid && in_tready;

  sacc_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_busy, .clr_last, .in_ready(in_tready), .cmd
  );

  sacc_dpath #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS), .ADDR_BITS(ADDR_BITS)) u_dpath (
    .clk, .rst_n, .cfg(cfg_r), .in_fire, .in_addr(in_tdata[31:0]), .in_cmd(in_tdata[32]),
    .cmd, .out_tready, .clr_last, .out_busy, .out_tvalid, .out_tdata
  );

endmodule

FILE: rtl/sacc_ctrl.sv
module sacc_ctrl
  import sacc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      out_busy,
  input  logic      clr_last,
  output logic      in_ready,
  output sacc_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_fire) state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  assign in_ready   = (state_r == ST_IDLE) && !out_busy;
  assign cmd.clear  = (state_r == ST_CLEAR);
  assign cmd.lookup = (state_r == ST_LOOKUP);
  assign cmd.update = (state_r == ST_UPDATE);

endmodule

FILE: rtl/sacc_dpath.sv
module sacc_dpath
  import sacc_pkg::*;
#(
  parameter int MAX_SETS  = MAX_SETS_DEF,
  parameter int MAX_WAYS  = MAX_WAYS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sacc_cfg_t            cfg,
  input  logic                 in_fire,
  input  logic [31:0]          in_addr,
  input  logic                 in_cmd,
  input  sacc_cmd_t            cmd,
  input  logic                 out_tready,
  output logic                 clr_last,
  output logic                 out_busy,
  output logic                 out_tvalid,
  output logic [135:0]         out_tdata
);

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int META_W = TAG_W + 2;
  localparam int VLD    = META_W - 1;
  localparam int DRT    = META_W - 2;

  // one bank per way: valid, dirty, tag
  logic [META_W-1:0]  meta_mem  [MAX_WAYS][MAX_SETS];
  logic [STAMP_W-1:0] stamp_mem [MAX_WAYS][MAX_SETS];
  logic [FPTR_W-1:0]  fptr_mem  [MAX_SETS];

  logic [SET_W-1:0]   clr_idx_r;
  logic               wr_r;
  logic [SET_W-1:0]   set_r;
  logic [TAG_W-1:0]   tag_r;
  logic [3:0]         ways_r;
  logic [META_W-1:0]  meta_rd_r  [MAX_WAYS];
  logic [STAMP_W-1:0] stamp_rd_r [MAX_WAYS];
  logic [FPTR_W-1:0]  fp_rd_r;
  logic               hit_r;
  logic [WAY_W-1:0]   way_r;
  logic [STAMP_W-1:0] access_stamp_r;
  logic [CNT_W-1:0]   hit_cnt_r, miss_cnt_r, rd_cnt_r, wr_cnt_r;
  logic [135:0]       out_r;
  logic               out_v_r;

  logic [31:0] am;
  logic [3:0]  bb, sb;
  logic [31:0] sh;
  logic [8:0]  rem;
  logic [SET_W-1:0] set_c;
  logic [3:0]  ways_c;
  always_comb begin
    am = in_addr & ((ADDR_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << ADDR_BITS) - 32'd1));
    bb = (cfg.blk_bits < 4'd2) ? 4'd2 : ((cfg.blk_bits > 4'd12) ? 4'd12 : cfg.blk_bits);
    sb = (cfg.set_bits > 4'd8) ? 4'd8 : cfg.set_bits;
    sh = am >> bb;
    rem = 9'(sh & ((32'd1 << sb) - 32'd1));
    // wrap the set index into MAX_SETS by compare and subtract
    for (int j = 8; j >= 0; j--) begin
      if (32'(rem) >= (32'(MAX_SETS) << j)) rem = rem - 9'(32'(MAX_SETS) << j);
    end
    set_c = SET_W'(rem);
    ways_c = ((5'd1 << cfg.ways_log2) > 5'(MAX_WAYS)) ? 4'(MAX_WAYS)
           : 4'(5'd1 << cfg.ways_log2);
  end

  logic             hit_c;
  logic [WAY_W-1:0] hway_c, lway_c, way_c;
  logic [STAMP_W-1:0] ls_c;
  always_comb begin
    hit_c  = 1'b0;
    hway_c = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < int'(ways_r) && meta_rd_r[w][VLD] && meta_rd_r[w][TAG_W-1:0] == tag_r) begin
        hit_c  = 1'b1;
        hway_c = WAY_W'(w);
      end
    end
    lway_c = '0;
    ls_c   = stamp_rd_r[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (w < int'(ways_r) && stamp_rd_r[w] < ls_c) begin
        lway_c = WAY_W'(w);
        ls_c   = stamp_rd_r[w];
      end
    end
    if (hit_c)               way_c = hway_c;
    else if (ways_r <= 4'd1) way_c = '0;
    else if (cfg.use_lru)    way_c = lway_c;
    else                     way_c = WAY_W'(4'(fp_rd_r) & (ways_r - 4'd1));
  end

  logic [META_W-1:0] vmeta, meta_wd;
  logic [1:0]        wr_add_c;
  logic              fp_adv;
  always_comb begin
    vmeta    = meta_rd_r[way_r];
    wr_add_c = 2'd0;
    if (!hit_r && vmeta[VLD] && vmeta[DRT]) wr_add_c = wr_add_c + 2'd1;
    if (wr_r && !cfg.write_back)            wr_add_c = wr_add_c + 2'd1;
    meta_wd = {1'b1, (hit_r && vmeta[DRT]) || (wr_r && cfg.write_back), tag_r};
    fp_adv  = cmd.update && !hit_r && ways_r > 4'd1 && !cfg.use_lru;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      wr_r    <= in_cmd;
      set_r   <= set_c;
      tag_r   <= TAG_W'(sh);
      ways_r  <= ways_c;
      fp_rd_r <= fptr_mem[set_c];
      for (int w = 0; w < MAX_WAYS; w++) begin
        meta_rd_r[w]  <= meta_mem[w][set_c];
        stamp_rd_r[w] <= stamp_mem[w][set_c];
      end
    end
    if (cmd.lookup) begin
      hit_r <= hit_c;
      way_r <= way_c;
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (cmd.clear) begin
        meta_mem[w][clr_idx_r]  <= '0;
        stamp_mem[w][clr_idx_r] <= '0;
      end else if (cmd.update && way_r == WAY_W'(w)) begin
        meta_mem[w][set_r]  <= meta_wd;
        stamp_mem[w][set_r] <= access_stamp_r;
      end
    end
    if (cmd.clear)   fptr_mem[clr_idx_r] <= '0;
    else if (fp_adv) fptr_mem[set_r]     <= fp_rd_r + FPTR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_r <= {1'b0, wr_cnt_r + CNT_W'(wr_add_c), rd_cnt_r + CNT_W'(!hit_r),
                miss_cnt_r + CNT_W'(!hit_r), hit_cnt_r + CNT_W'(hit_r),
                3'(way_r), wr_add_c, !hit_r, hit_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      access_stamp_r <= 32'd1;
      hit_cnt_r <= '0; miss_cnt_r <= '0; rd_cnt_r <= '0; wr_cnt_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (cmd.clear) clr_idx_r <= clr_idx_r + SET_W'(1);
      out_v_r <= cmd.update ? 1'b1 : (out_v_r && !out_tready);
      if (cmd.update) begin
        access_stamp_r <= access_stamp_r + 32'd1;
        wr_cnt_r       <= wr_cnt_r + CNT_W'(wr_add_c);
        if (hit_r) begin
          hit_cnt_r <= hit_cnt_r + 32'd1;
        end else begin
          miss_cnt_r <= miss_cnt_r + 32'd1;
          rd_cnt_r   <= rd_cnt_r + 32'd1;
        end
      end
    end
  end

  assign clr_last   = (clr_idx_r == SET_W'(MAX_SETS - 1));
  assign out_busy   = out_v_r && !out_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

endmodule

FILE: rtl/sacc_checker.sv
module sacc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[0] != out_tdata[1])
    else $error("hit and fill disagree");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken during access");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##3 out_tvalid)
    else $error("result missing");

endmodule

bind set_assoc_cache_controller_top sacc_checker u_sacc_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);

FILE: bench/set_assoc_cache_controller_top_tb.sv
module set_assoc_cache_controller_top_tb;
  import sacc_pkg::*;

  typedef struct {
    logic [31:0] addr;
    logic        cmd;
  } access_t;

  typedef struct {
    logic        hit;
    logic        fill;
    logic [1:0]  writes;
    logic [2:0]  way;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] reads;
    logic [31:0] wrs;
  } outcome_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [39:0]           in_tdata;   // address[31:0], command[32]
  logic                  out_tvalid;
  logic                  out_tready;
  // hit, line_fill, writes_added[1:0], way_used[2:0], hit/miss/read/write totals
  logic [135:0]          out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  set_assoc_cache_controller_top i_dut (.*);

  access_t  pending[$];
  outcome_t outcomes[$];
  int       failures = 0;
  int       tx_gap = 0;
  int       rx_gap = 0;
  bit       quiet = 0;

  // cache shadow
  bit          sh_lru = 0, sh_wb = 0;
  bit [3:0]    sh_blk = 5, sh_set = 4;
  bit [1:0]    sh_ways = 0;
  bit [29:0]   tags[2048];
  bit          valid[2048];
  bit          dirty[2048];
  bit [31:0]   stamps[2048];
  bit [2:0]    fptr[256];
  bit [31:0]   stamp_now = 1;
  bit [31:0]   hit_cnt = 0, miss_cnt = 0, read_cnt = 0, write_cnt = 0;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int eff_blk();
    return (sh_blk < 2) ? 2 : (sh_blk > 12) ? 12 : sh_blk;
  endfunction

  function automatic int eff_set();
    return (sh_set > 8) ? 8 : sh_set;
  endfunction

  task automatic lookup_access(input logic [31:0] addr, input logic cmd);
    int       bb, sb, nways, set, base, way, w;
    bit [29:0] tag;
    outcome_t o;
    bit       hit;
    bit [1:0] wr;
    bb = eff_blk();
    sb = eff_set();
    nways = 1 << sh_ways;
    set = ((addr >> bb) & ((1 << sb) - 1)) % 256;
    tag = 30'((addr >> bb) & 32'h3FFF_FFFF);
    base = set * 8;
    hit = 0;
    way = 0;
    wr = 0;
    for (w = 0; w < nways; w++) begin
      if (!hit && valid[base + w] && tags[base + w] == tag) begin
        hit = 1;
        way = w;
      end
    end
    if (hit) begin
      hit_cnt++;
      if (cmd) begin
        if (sh_wb) dirty[base + way] = 1;
        else wr++;
      end
    end else begin
      if (nways <= 1) begin
        way = 0;
      end else if (sh_lru) begin
        way = 0;
        for (w = 1; w < nways; w++)
          if (stamps[base + w] < stamps[base + way]) way = w;
      end else begin
        way = fptr[set] % nways;
        fptr[set] = fptr[set] + 3'd1;
      end
      miss_cnt++;
      read_cnt++;
      if (valid[base + way] && dirty[base + way]) wr++;
      dirty[base + way] = 0;
      tags[base + way] = tag;
      valid[base + way] = 1;
      if (cmd) begin
        if (sh_wb) dirty[base + way] = 1;
        else wr++;
      end
    end
    write_cnt += wr;
    stamps[base + way] = stamp_now;
    stamp_now++;
    o.hit = hit;
    o.fill = !hit;
    o.writes = wr;
    o.way = 3'(way);
    o.hits = hit_cnt;
    o.misses = miss_cnt;
    o.reads = read_cnt;
    o.wrs = write_cnt;
    outcomes.push_back(o);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      failures++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    logic        nv;
    logic [39:0] nd;
    access_t     a;
    nv = in_tvalid;
    nd = in_tdata;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        lookup_access(in_tdata[31:0], in_tdata[32]);
        nv = 1'b0;
      end
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending.size() > 0) begin
          a = pending.pop_front();
          nd = {7'b0, a.cmd, a.addr};
          nv = 1'b1;
          if (!quiet && $urandom_range(0, 3) == 0) tx_gap = $urandom_range(1, 6);
        end
      end
    end
    in_tvalid <= nv;
    in_tdata <= nd;
  end

  // monitor
  always @(posedge clk) begin
    logic     nr;
    outcome_t e;
    nr = out_tready;
    if (!rst_n) begin
      nr = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (outcomes.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, out_tdata);
          failures++;
        end else begin
          e = outcomes.pop_front();
          check_field("hit", e.hit, out_tdata[0]);
          check_field("line_fill", e.fill, out_tdata[1]);
          check_field("writes_added", e.writes, out_tdata[3:2]);
          check_field("way_used", e.way, out_tdata[6:4]);
          check_field("hit_total", e.hits, out_tdata[38:7]);
          check_field("miss_total", e.misses, out_tdata[70:39]);
          check_field("read_total", e.reads, out_tdata[102:71]);
          check_field("write_total", e.wrs, out_tdata[134:103]);
        end
      end
      if (rx_gap > 0) begin
        rx_gap--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) begin
          rx_gap = $urandom_range(1, 6);
          nr = 1'b0;
        end
      end
    end
    out_tready <= nr;
  end

  task automatic add(input logic [31:0] addr, input logic cmd);
    access_t a;
    a.addr = addr;
    a.cmd = cmd;
    pending.push_back(a);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending.size() != 0 || in_tvalid || outcomes.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [3:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      CFG_USE_LRU:    sh_lru = val[0];
      CFG_WRITE_BACK: sh_wb = val[0];
      CFG_BLK_BITS:   sh_blk = val;
      CFG_SET_BITS:   sh_set = val;
      CFG_WAYS_LOG2:  sh_ways = val[1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_random(input int n);
    int          bb, sb, i;
    logic [31:0] addr;
    bb = eff_blk();
    sb = eff_set();
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        addr = $urandom;
      end else begin
        addr = ($urandom_range(0, 23) << (bb + sb)) | ($urandom_range(0, 3) << bb)
             | ($urandom & ((1 << bb) - 1));
        if ($urandom_range(0, 3) == 0) addr = addr ^ 32'hF000_0000;
      end
      add(addr, $urandom_range(0, 1));
    end
  endtask

  initial begin
    int p;
    logic [3:0] cfgs[6][5] = '{
      '{1, 1, 2, 0, 3},
      '{0, 1, 12, 8, 2},
      '{1, 0, 0, 15, 1},
      '{0, 0, 15, 2, 3},
      '{1, 1, 4, 1, 2},
      '{0, 1, 6, 3, 3}
    };
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_USE_LRU;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    add(32'h0000_0000, 1'b0);
    add(32'h0000_0000, 1'b1);
    add(32'hFFFF_FFFF, 1'b1);
    add(32'hFFFF_FFFF, 1'b0);
    add(32'h0000_0200, 1'b1);
    add(32'h0000_0000, 1'b0);
    add(32'h8000_0000, 1'b0);
    add(32'h0000_001F, 1'b1);
    add(32'h7FFF_FFE0, 1'b1);
    drain();
    write_reg(CFG_USE_LRU, 4'd0);
    write_reg(CFG_WRITE_BACK, 4'd1);
    add(32'h0000_0040, 1'b1);
    add(32'h0000_0240, 1'b0);
    add(32'h0000_0240, 1'b1);
    add(32'h0000_0040, 1'b0);
    add_random(40);
    drain();

    for (p = 0; p < 6; p++) begin
      if (p == 5) quiet = 1;
      write_reg(CFG_USE_LRU, cfgs[p][0]);
      write_reg(CFG_WRITE_BACK, cfgs[p][1]);
      write_reg(CFG_BLK_BITS, cfgs[p][2]);
      write_reg(CFG_SET_BITS, cfgs[p][3]);
      write_reg(CFG_WAYS_LOG2, cfgs[p][4]);
      add_random(60);
      drain();
    end

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
